>>> sv/energy_vad_with_high_pass_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the energy VAD block
// Shared property forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VAD_WITH_HIGH_PASS_TOP_ASSERT_SVH
`define ENERGY_VAD_WITH_HIGH_PASS_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EVAD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define EVAD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/evad_pkg.sv
// ----------------------------------------------------------------------------
// Energy VAD package
// Widths, reset values, register indexes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package evad_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int ALPHA_W         = 16;
    localparam int THR_W           = 15;
    localparam int MEAN_W          = 15;
    localparam int SUM_W           = 30;
    localparam int COUNT_W         = 15;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int DIV_STEPS       = SUM_W;
    localparam int STEP_W          = 5;
    localparam int MAX_SAMPLES_DEF = 16384;
    localparam int COUNT_LIMIT     = 32767;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd63060;
    localparam logic [THR_W-1:0]   THR_RESET       = 15'd3;
    localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0]  MEAN_MAX        = {MEAN_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE = 2'd0,
        CFG_ALPHA         = 2'd1,
        CFG_VAD_THRESHOLD = 2'd2
    } evad_cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic mul;       // register the filter product
        logic acc;       // filter output, history, sum and count update
        logic div_step;  // one restoring division step
        logic finish;    // load the result, clear the block state
    } evad_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;      // captured item ends the block
        logic out_free;  // output register can take a result
    } evad_sts_t;

endpackage

`default_nettype wire

>>> sv/energy_vad_with_high_pass_top.sv
// ----------------------------------------------------------------------------
// Energy voice activity detector with one-pole high-pass pre-filter
// Filters each sample, sums magnitudes over a block, reports the mean level
// and a speech flag at the block's last sample.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                        Content
//  --------  ---------  -----------------------------  ---------------------------
//  s_        in         s_tvalid s_tready s_tdata      sample [15:0], last on tlast
//                       s_tlast
//  m_        out        m_tvalid m_tready m_tdata      speech_detected [0],
//                                                      mean_level [15:1]
//  cfg_      in         cfg_we cfg_index cfg_data      0 filter_enable, 1 alpha,
//                                                      2 vad_threshold
//
//  Each sample passes capture, the 17x18 filter multiply, then
//  round/saturate and accumulate. A last sample then runs the bit-serial
//  sum/count division and loads the result register.
//  Reset clears the filter history, sum and count and restores the register
//  defaults; the next sample starts a new block.
//  A result waiting in the output register does not stall the next block;
//  only a second finished block stalls, in its load cycle, until m_tready.
//  Write configuration only between blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module energy_vad_with_high_pass_top
    import evad_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // sample stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] sample
    input  wire logic                  s_tlast,   // last sample of the block
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata    // [0] speech_detected, [15:1] mean_level
);

    evad_cmd_t cmd;
    evad_sts_t sts;

    // sequence the per-sample steps and the division
    evad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // filter, accumulate, divide and hold the result
    evad_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> sv/evad_ctrl.sv
// ----------------------------------------------------------------------------
// Energy VAD controller
// Sequences capture, filter, accumulate, divide and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "energy_vad_with_high_pass_top_assert.svh"

module evad_ctrl
    import evad_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire evad_sts_t sts,
    output evad_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc   = 1'b1;
                step_next = '0;
                state_next = sts.last ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `EVAD_ASSERT_NEXT(a_accept_blocks, clk, rst_n, s_tvalid && s_tready, !s_tready, "accept not followed by busy")
    `EVAD_ASSERT_NOW(a_finish_free, clk, rst_n, cmd.finish, sts.out_free, "result loaded over a pending one")
    `EVAD_ASSERT_NEXT(a_last_divides, clk, rst_n, (state_reg == S_ACC) && sts.last, state_reg == S_DIV, "last item did not start division")

endmodule

`default_nettype wire

>>> sv/evad_dp.sv
// ----------------------------------------------------------------------------
// Energy VAD datapath
// High-pass filter, magnitude sum, sample count, serial divider, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "energy_vad_with_high_pass_top_assert.svh"

module evad_dp
    import evad_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [SAMPLE_W-1:0]   s_tdata,
    input  wire logic                  s_tlast,
    input  wire evad_cmd_t             cmd,
    output evad_sts_t                  sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata
);

    localparam int CAP_INT = (MAX_SAMPLES < COUNT_LIMIT) ? MAX_SAMPLES : COUNT_LIMIT;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP_INT);

    // configuration
    logic                       enable_reg;
    logic [ALPHA_W-1:0]         alpha_reg;
    logic [THR_W-1:0]           thr_reg;

    // block state
    logic signed [SAMPLE_W-1:0] prev_in_reg, prev_out_reg;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       first_reg;

    // item and working registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic signed [34:0]         prod_reg;
    logic [COUNT_W-1:0]         rem_reg, rem_next;

    // result
    logic                       valid_reg;
    logic                       speech_reg;
    logic [MEAN_W-1:0]          mean_reg;

    logic signed [17:0]         diff;
    logic signed [34:0]         prod_rnd;
    logic signed [18:0]         y_wide;
    logic signed [SAMPLE_W-1:0] y_filt, y_sel;
    logic [16:0]                mag_wide;
    logic [SUM_W:0]             sum_add;
    logic [COUNT_W:0]           rem_sh;
    logic                       q_bit;
    logic [MEAN_W-1:0]          mean_val;

    // d = y_prev + x - x_prev, exact in 18 bits
    assign diff = 18'(prev_out_reg) + 18'(x_reg) - 18'(prev_in_reg);

    // round half up then floor by 2^16, saturate to Q1.15
    assign prod_rnd = prod_reg + 35'sd32768;
    assign y_wide   = prod_rnd[34:16];

    always_comb
    begin
        if (y_wide > 19'sd32767)
        begin
            y_filt = 16'sh7FFF;
        end
        else if (y_wide < -19'sd32768)
        begin
            y_filt = 16'sh8000;
        end
        else
        begin
            y_filt = y_wide[15:0];
        end
    end

    // first item of a block and bypass mode pass the sample through
    assign y_sel    = (first_reg || !enable_reg) ? x_reg : y_filt;
    assign mag_wide = y_sel[15] ? (17'd0 - {y_sel[15], y_sel}) : {1'b0, y_sel};
    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(mag_wide);

    // restoring division: sum_reg shifts out dividend and in quotient bits
    assign rem_sh = {rem_reg, sum_reg[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, count_reg});

    assign mean_val = (|sum_reg[SUM_W-1:MEAN_W]) ? MEAN_MAX : sum_reg[MEAN_W-1:0];

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        if (cmd.acc)
        begin
            sum_next   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
            count_next = (count_reg < CAP_C) ? count_reg + 1'b1 : count_reg;
            rem_next   = '0;
        end
        else if (cmd.div_step)
        begin
            sum_next = {sum_reg[SUM_W-2:0], q_bit};
            rem_next = q_bit ? COUNT_W'(rem_sh - {1'b0, count_reg}) : rem_sh[COUNT_W-1:0];
        end
        else if (cmd.finish)
        begin
            sum_next   = '0;
            count_next = '0;
        end
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            alpha_reg    <= ALPHA_RESET;
            thr_reg      <= THR_RESET;
            prev_in_reg  <= '0;
            prev_out_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            first_reg    <= 1'b1;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILTER_ENABLE: enable_reg <= cfg_data[0];
                    CFG_ALPHA:         alpha_reg  <= cfg_data[ALPHA_W-1:0];
                    CFG_VAD_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                    default:           ;
                endcase
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
            if (cmd.acc)
            begin
                prev_in_reg  <= x_reg;
                prev_out_reg <= y_sel;
                first_reg    <= 1'b0;
            end
            else if (cmd.finish)
            begin
                first_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed({1'b0, alpha_reg}) * diff;
        end
        rem_reg <= rem_next;
        if (cmd.finish)
        begin
            mean_reg   <= mean_val;
            speech_reg <= (mean_val >= thr_reg);
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_free = !valid_reg || m_tready;
    assign m_tvalid     = valid_reg;
    assign m_tdata      = {mean_reg, speech_reg};

    `EVAD_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, m_tvalid, "result not presented")
    `EVAD_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CAP_C, "sample count above cap")
    `EVAD_ASSERT_NEXT(a_finish_clears, clk, rst_n, cmd.finish, first_reg && (sum_reg == '0) && (count_reg == '0), "block state not cleared")

endmodule

`default_nettype wire
